// ===== src/wphs_pkg.sv =====
// Package: shared constants, codes and types of the windowed probe hash set.
`default_nettype none
package wphs_pkg;

  // Table geometry defaults
  localparam int unsigned CAPACITY_DEF     = 1024;
  localparam int unsigned PROBE_WINDOW_DEF = 8;

  // Fixed field widths
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned OUT_W   = 2;
  localparam int unsigned ENTRY_W = 11;

  // 64-bit finalizer constants
  localparam logic [KEY_W-1:0] MIX_C1 = 64'hff51afd7ed558ccd;
  localparam logic [KEY_W-1:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_TEST   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;  // unused, answers as a test

  // Outcome codes
  localparam logic [OUT_W-1:0] OUT_ABSENT   = 2'd0;
  localparam logic [OUT_W-1:0] OUT_PRESENT  = 2'd1;
  localparam logic [OUT_W-1:0] OUT_INSERTED = 2'd2;
  localparam logic [OUT_W-1:0] OUT_FULL     = 2'd3;

  // Multiplier partial-product step codes
  localparam logic [1:0] MSTEP_LL = 2'd0;
  localparam logic [1:0] MSTEP_LH = 2'd1;
  localparam logic [1:0] MSTEP_HL = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MIX1,
    ST_MIX2,
    ST_REDUCE,
    ST_PROBE
  } state_e;

endpackage
`default_nettype wire

// ===== src/windowed_probe_hash_set.sv =====
// Top level: hash set of nonzero 64-bit keys with windowed linear probing.
`default_nettype none
// Usage
//   Request channel: drive mode_i/key_i and raise start_i; the request is
//   taken at a rising edge with start_i high and busy_o low. mode_i is test,
//   insert or delete (the unused code answers as a test).
//   Result channel: done_o pulses for one cycle with outcome_o and
//   entry_count_o (occupied slots after the request). The receiver cannot
//   stall; the result must be captured in that cycle.
// Timing
//   The key goes through the 64-bit finalizer on one shared 32x32 multiplier:
//   three partial products per multiply, two multiplies. Then the window is
//   walked through the table RAM read port, one slot read per cycle, each
//   compared in the cycle after its read; a zero key answers in the next
//   cycle. A CAPACITY that is not a power of two adds a reduction before the
//   walk: the hash is reduced in four 16-bit digits, each a reciprocal
//   multiply, a multiply-back on the same multiplier and a conditional
//   subtract. busy_o drops in the cycle done_o shows.
// Reset
//   After reset a clearing pass writes zero to all CAPACITY slots, one per
//   cycle; busy_o stays high meanwhile.
module windowed_probe_hash_set #(
  parameter int unsigned CAPACITY     = wphs_pkg::CAPACITY_DEF,
  parameter int unsigned PROBE_WINDOW = wphs_pkg::PROBE_WINDOW_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic [wphs_pkg::MODE_W-1:0]  mode_i,
  input  wire logic [wphs_pkg::KEY_W-1:0]   key_i,
  output logic                              done_o,
  output logic [wphs_pkg::OUT_W-1:0]        outcome_o,
  output logic [wphs_pkg::ENTRY_W-1:0]      entry_count_o
);

  localparam int unsigned KW   = wphs_pkg::KEY_W;
  localparam int unsigned IDXW = $clog2(CAPACITY);
  localparam int unsigned CNTW = $clog2(CAPACITY + 1);
  localparam int unsigned WINW = $clog2(PROBE_WINDOW + 1);
  localparam bit          POW2 = (CAPACITY & (CAPACITY - 1)) == 0;
  localparam logic [IDXW-1:0] LAST_SLOT = IDXW'(CAPACITY - 1);
  // reduction: four 16-bit digits, quotient estimate off by at most one
  localparam logic [1:0]      LAST_DIG  = 2'(KW / 16 - 1);
  localparam logic [31:0]     RECIP     = 32'((64'd1 << 32) / 64'(CAPACITY));
  localparam logic [31:0]     CAP_W     = 32'(CAPACITY);

  // Control state
  wphs_pkg::state_e state_q, state_d;
  logic [IDXW-1:0]  clr_q, clr_d;
  logic [1:0]       mstep_q, mstep_d;
  logic [1:0]       bit_q, bit_d;
  logic [WINW-1:0]  issue_q, issue_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic             cmp_last_q, cmp_last_d;
  logic [CNTW-1:0]  count_q, count_d;
  logic             done_q, done_d;

  // Payload state
  logic [wphs_pkg::MODE_W-1:0] mode_q, mode_d;
  logic [KW-1:0]               key_q, key_d;
  logic [KW-1:0]               k_q, k_d;     // hash work register / shifter
  logic [KW-1:0]               acc_q, acc_d; // multiply accumulator
  logic [KW-1:0]               p_q, p_d;     // hash + probe index, 64-bit wrap
  logic [IDXW-1:0]             slot_q, slot_d;
  logic [IDXW-1:0]             cmp_slot_q, cmp_slot_d;
  logic [wphs_pkg::OUT_W-1:0]  outcome_q, outcome_d;

  // Table RAM
  logic [KW-1:0]   mem [CAPACITY];
  logic [KW-1:0]   rdata_q;
  logic            rd_en;
  logic [IDXW-1:0] rd_addr;
  logic            wr_en;
  logic [IDXW-1:0] wr_addr;
  logic [KW-1:0]   wr_data;

  // Shared multiplier
  logic [31:0]   mul_a, mul_b;
  logic [KW-1:0] prod, acc_sum, hash_step;
  logic [KW-1:0] mix_c;

  // Probe decision
  logic            is_ins, is_del, hit, empty, probe_end;
  logic [31:0]     red_y;

  assign mix_c = (state_q == wphs_pkg::ST_MIX1) ? wphs_pkg::MIX_C1 : wphs_pkg::MIX_C2;

  always_comb begin
    if (state_q == wphs_pkg::ST_REDUCE) begin
      // quotient estimate first, then quotient times capacity
      if (mstep_q == wphs_pkg::MSTEP_LL) begin
        mul_a = red_y;
        mul_b = RECIP;
      end else begin
        mul_a = acc_q[31:0];
        mul_b = CAP_W;
      end
    end else begin
      case (mstep_q)
        wphs_pkg::MSTEP_LL: begin
          mul_a = k_q[31:0];
          mul_b = mix_c[31:0];
        end
        wphs_pkg::MSTEP_LH: begin
          mul_a = k_q[31:0];
          mul_b = mix_c[63:32];
        end
        default: begin
          mul_a = k_q[63:32];
          mul_b = mix_c[31:0];
        end
      endcase
    end
  end

  assign prod      = mul_a * mul_b;
  // cross products only reach the upper word
  assign acc_sum   = acc_q + {prod[31:0], 32'h0};
  assign hash_step = acc_sum ^ (acc_sum >> 33);

  // digit step: y = rem * 2^16 + next hash digit, rem < CAPACITY <= 2^16
  assign red_y = {16'(slot_q), k_q[KW-1 -: 16]};

  assign is_ins    = mode_q == wphs_pkg::MODE_INSERT;
  assign is_del    = mode_q == wphs_pkg::MODE_DELETE;
  assign hit       = rdata_q == key_q;
  assign empty     = rdata_q == '0;
  assign probe_end = cmp_vld_q && (hit || (is_ins && empty) || cmp_last_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wphs_pkg::ST_CLEAR:  if (clr_q == LAST_SLOT) state_d = wphs_pkg::ST_IDLE;
      wphs_pkg::ST_IDLE: begin
        if (start_i && key_i != '0) state_d = wphs_pkg::ST_MIX1;
      end
      wphs_pkg::ST_MIX1:   if (mstep_q == wphs_pkg::MSTEP_HL) state_d = wphs_pkg::ST_MIX2;
      wphs_pkg::ST_MIX2: begin
        if (mstep_q == wphs_pkg::MSTEP_HL) begin
          state_d = POW2 ? wphs_pkg::ST_PROBE : wphs_pkg::ST_REDUCE;
        end
      end
      wphs_pkg::ST_REDUCE: begin
        if (mstep_q == wphs_pkg::MSTEP_HL && bit_q == LAST_DIG) state_d = wphs_pkg::ST_PROBE;
      end
      wphs_pkg::ST_PROBE:  if (probe_end) state_d = wphs_pkg::ST_IDLE;
      default:             state_d = wphs_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    clr_d      = clr_q;
    mstep_d    = mstep_q;
    bit_d      = bit_q;
    issue_d    = issue_q;
    cmp_vld_d  = 1'b0;
    cmp_last_d = cmp_last_q;
    cmp_slot_d = cmp_slot_q;
    count_d    = count_q;
    done_d     = 1'b0;
    mode_d     = mode_q;
    key_d      = key_q;
    k_d        = k_q;
    acc_d      = acc_q;
    p_d        = p_q;
    slot_d     = slot_q;
    outcome_d  = outcome_q;
    rd_en      = 1'b0;
    rd_addr    = slot_q;
    wr_en      = 1'b0;
    wr_addr    = cmp_slot_q;
    wr_data    = '0;
    unique case (state_q)
      wphs_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        clr_d   = clr_q + 1'b1;
      end
      wphs_pkg::ST_IDLE: begin
        if (start_i) begin
          mode_d  = mode_i;
          key_d   = key_i;
          k_d     = key_i ^ (key_i >> 33);
          mstep_d = wphs_pkg::MSTEP_LL;
          if (key_i == '0) begin
            // zero marks an empty slot and is never a member
            done_d    = 1'b1;
            outcome_d = wphs_pkg::OUT_ABSENT;
          end
        end
      end
      wphs_pkg::ST_MIX1, wphs_pkg::ST_MIX2: begin
        case (mstep_q)
          wphs_pkg::MSTEP_LL: begin
            acc_d   = prod;
            mstep_d = wphs_pkg::MSTEP_LH;
          end
          wphs_pkg::MSTEP_LH: begin
            acc_d   = acc_sum;
            mstep_d = wphs_pkg::MSTEP_HL;
          end
          default: begin
            k_d     = hash_step;
            mstep_d = wphs_pkg::MSTEP_LL;
            if (state_q == wphs_pkg::ST_MIX2) begin
              p_d     = hash_step;
              slot_d  = POW2 ? hash_step[IDXW-1:0] : '0;
              bit_d   = '0;
              issue_d = '0;
            end
          end
        endcase
      end
      wphs_pkg::ST_REDUCE: begin
        case (mstep_q)
          wphs_pkg::MSTEP_LL: begin
            acc_d   = {32'h0, prod[63:32]};
            mstep_d = wphs_pkg::MSTEP_LH;
          end
          wphs_pkg::MSTEP_LH: begin
            acc_d   = {32'h0, red_y - prod[31:0]};
            mstep_d = wphs_pkg::MSTEP_HL;
          end
          default: begin
            // partial remainder is below twice the capacity
            slot_d  = (acc_q[31:0] >= CAP_W) ? IDXW'(acc_q[31:0] - CAP_W) :
                                               IDXW'(acc_q[31:0]);
            k_d     = k_q << 16;
            bit_d   = bit_q + 1'b1;
            mstep_d = wphs_pkg::MSTEP_LL;
          end
        endcase
      end
      wphs_pkg::ST_PROBE: begin
        // issue the next window read; compare runs in the cycle after the read
        if (issue_q != WINW'(PROBE_WINDOW) && !probe_end) begin
          rd_en      = 1'b1;
          issue_d    = issue_q + 1'b1;
          cmp_vld_d  = 1'b1;
          cmp_slot_d = slot_q;
          cmp_last_d = issue_q == WINW'(PROBE_WINDOW - 1);
          p_d        = p_q + 1'b1;
          if (p_q == '1) begin
            slot_d = '0;  // 64-bit index wrapped to zero
          end else begin
            slot_d = (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
          end
        end
        if (cmp_vld_q) begin
          if (hit) begin
            outcome_d = wphs_pkg::OUT_PRESENT;
            if (is_del) begin
              wr_en   = 1'b1;
              count_d = count_q - 1'b1;
            end
          end else if (is_ins && empty) begin
            wr_en     = 1'b1;
            wr_data   = key_q;
            count_d   = count_q + 1'b1;
            outcome_d = wphs_pkg::OUT_INSERTED;
          end else if (cmp_last_q) begin
            outcome_d = is_ins ? wphs_pkg::OUT_FULL : wphs_pkg::OUT_ABSENT;
          end
          done_d = probe_end;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= wphs_pkg::ST_CLEAR;
      clr_q      <= '0;
      mstep_q    <= wphs_pkg::MSTEP_LL;
      bit_q      <= '0;
      issue_q    <= '0;
      cmp_vld_q  <= 1'b0;
      cmp_last_q <= 1'b0;
      count_q    <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      mstep_q    <= mstep_d;
      bit_q      <= bit_d;
      issue_q    <= issue_d;
      cmp_vld_q  <= cmp_vld_d;
      cmp_last_q <= cmp_last_d;
      count_q    <= count_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    key_q      <= key_d;
    k_q        <= k_d;
    acc_q      <= acc_d;
    p_q        <= p_d;
    slot_q     <= slot_d;
    cmp_slot_q <= cmp_slot_d;
    outcome_q  <= outcome_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  assign busy_o        = state_q != wphs_pkg::ST_IDLE;
  assign done_o        = done_q;
  assign outcome_o     = outcome_q;
  assign entry_count_o = wphs_pkg::ENTRY_W'(count_q);

  // Assertions
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNTW'(CAPACITY))
    else $error("occupancy above capacity");

  a_count_moves_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> done_o)
    else $error("occupancy changed without a result");

  a_insert_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && outcome_o == wphs_pkg::OUT_INSERTED) |-> count_q == $past(count_q) + 1'b1)
    else $error("insert did not bump occupancy");

  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wphs_pkg::ST_CLEAR) |-> (count_q == '0 && !done_o))
    else $error("activity during clearing pass");

endmodule
`default_nettype wire

// ===== tb/windowed_probe_hash_set_tb.sv =====
// Testbench: windowed_probe_hash_set checked request by request against a behavioral hash set.
`timescale 1ns / 100ps
module windowed_probe_hash_set_tb;

  localparam int unsigned CAP = wphs_pkg::CAPACITY_DEF;
  localparam int unsigned PW  = wphs_pkg::PROBE_WINDOW_DEF;

  // Number of random requests, and of trailing ones sent back to back, no gaps.
  localparam int unsigned RAND_REQS  = 950;
  localparam int unsigned TAIL_REQS  = 150;

  typedef struct packed {
    logic [wphs_pkg::OUT_W-1:0]   outcome;
    logic [wphs_pkg::ENTRY_W-1:0] entry_count;
  } hash_result_t;

  // Behavioral copy of the set plus the queue of results still owed by the DUT.
  class hash_set_scoreboard;
    logic [wphs_pkg::KEY_W-1:0] slots [CAP];
    int unsigned                occupied;
    hash_result_t               owed_q [$];
    int unsigned                mismatches;

    function new();
      foreach (slots[i]) slots[i] = '0;
      occupied   = 0;
      mismatches = 0;
    endfunction

    // 64-bit finalizer: xor-shift / multiply, twice.
    function logic [wphs_pkg::KEY_W-1:0] fmix(logic [wphs_pkg::KEY_W-1:0] k);
      logic [wphs_pkg::KEY_W-1:0] h;
      h = k ^ (k >> 33);
      h = h * wphs_pkg::MIX_C1;
      h = h ^ (h >> 33);
      h = h * wphs_pkg::MIX_C2;
      h = h ^ (h >> 33);
      return h;
    endfunction

    function int unsigned bucket_of(logic [wphs_pkg::KEY_W-1:0] key, int unsigned step);
      logic [wphs_pkg::KEY_W-1:0] s;
      s = fmix(key) + 64'(step);
      return int'(s % 64'(CAP));
    endfunction

    // Apply an accepted request to the shadow table and queue its result.
    function void note_request(logic [wphs_pkg::MODE_W-1:0] mode,
                               logic [wphs_pkg::KEY_W-1:0] key);
      hash_result_t r;
      int unsigned  idx;
      r.outcome = wphs_pkg::OUT_ABSENT;
      if (key != '0) begin
        if (mode == wphs_pkg::MODE_INSERT) begin
          r.outcome = wphs_pkg::OUT_FULL;
          for (int i = 0; i < PW; i++) begin
            idx = bucket_of(key, i);
            if (slots[idx] == key) begin
              r.outcome = wphs_pkg::OUT_PRESENT;
              break;
            end
            if (slots[idx] == '0) begin
              slots[idx] = key;
              occupied++;
              r.outcome = wphs_pkg::OUT_INSERTED;
              break;
            end
          end
        end else if (mode == wphs_pkg::MODE_DELETE) begin
          for (int i = 0; i < PW; i++) begin
            idx = bucket_of(key, i);
            if (slots[idx] == key) begin
              slots[idx] = '0;
              occupied--;
              r.outcome = wphs_pkg::OUT_PRESENT;
              break;
            end
          end
        end else begin
          // test, and the unused mode code answers the same way
          for (int i = 0; i < PW; i++) begin
            if (slots[bucket_of(key, i)] == key) begin
              r.outcome = wphs_pkg::OUT_PRESENT;
              break;
            end
          end
        end
      end
      r.entry_count = occupied[wphs_pkg::ENTRY_W-1:0];
      owed_q.push_back(r);
    endfunction

    function void check_result(logic [wphs_pkg::OUT_W-1:0] outcome,
                               logic [wphs_pkg::ENTRY_W-1:0] count);
      hash_result_t want;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected result outcome %0d entry_count %0d",
                 $time, outcome, count);
        mismatches++;
        return;
      end
      want = owed_q.pop_front();
      if (outcome !== want.outcome) begin
        $display("%0t: outcome expected %0d actual %0d", $time, want.outcome, outcome);
        mismatches++;
      end
      if (count !== want.entry_count) begin
        $display("%0t: entry_count expected %0d actual %0d",
                 $time, want.entry_count, count);
        mismatches++;
      end
    endfunction
  endclass

  logic                         clk_i;
  logic                         rst_ni  = 1'b0;
  logic                         start_i = 1'b0;
  logic [wphs_pkg::MODE_W-1:0]  mode_i  = wphs_pkg::MODE_TEST;
  logic [wphs_pkg::KEY_W-1:0]   key_i   = '0;
  logic                         busy_o;
  logic                         done_o;
  logic [wphs_pkg::OUT_W-1:0]   outcome_o;
  logic [wphs_pkg::ENTRY_W-1:0] entry_count_o;

  hash_set_scoreboard sb = new();

  // Keys whose home bucket sits in the few slots around the wrap point, so
  // their windows overlap, fill up and wrap from the last slot to slot 0.
  logic [wphs_pkg::KEY_W-1:0] crowd_keys [$];
  // Keys homed exactly at the last slot, for the directed full-window case.
  logic [wphs_pkg::KEY_W-1:0] wrap_keys  [$];
  // Fresh random keys that went in as inserts, reused for hits on test/delete.
  logic [wphs_pkg::KEY_W-1:0] seen_keys  [$];

  windowed_probe_hash_set #(
    .CAPACITY     (CAP),
    .PROBE_WINDOW (PW)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .mode_i        (mode_i),
    .key_i         (key_i),
    .done_o        (done_o),
    .outcome_o     (outcome_o),
    .entry_count_o (entry_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop in case the DUT hangs; far above the slowest legal run.
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // Results cannot be held off: sample every done_o pulse at the closing edge.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(outcome_o, entry_count_o);
  end

  // Present a request and hold it until the DUT takes it (start high, busy
  // low at an edge). start_i is left high so a following request can go out
  // without a bubble; idle_for drops it when a gap is wanted.
  task automatic send_request(input logic [wphs_pkg::MODE_W-1:0] mode,
                              input logic [wphs_pkg::KEY_W-1:0] key);
    start_i <= 1'b1;
    mode_i  <= mode;
    key_i   <= key;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_request(mode, key);
  endtask

  task automatic idle_for(input int unsigned n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // One random request: mostly crowded or reused keys so windows fill, holes
  // open and duplicates appear; the rest fresh random keys and odd cases.
  task automatic random_request();
    logic [wphs_pkg::MODE_W-1:0] mode;
    logic [wphs_pkg::KEY_W-1:0]  key;
    int unsigned                 pick;
    pick = $urandom_range(0, 99);
    if (pick < 40)      mode = wphs_pkg::MODE_INSERT;
    else if (pick < 65) mode = wphs_pkg::MODE_DELETE;
    else if (pick < 93) mode = wphs_pkg::MODE_TEST;
    else                mode = wphs_pkg::MODE_SPARE;   // must act as a test
    pick = $urandom_range(0, 99);
    if (pick < 2)
      key = '0;
    else if (pick < 47)
      key = crowd_keys[$urandom_range(0, crowd_keys.size() - 1)];
    else if (pick < 72 && seen_keys.size() != 0)
      key = seen_keys[$urandom_range(0, seen_keys.size() - 1)];
    else begin
      key = {$urandom, $urandom};
      if (key == '0) key = 64'd1;
      if (mode == wphs_pkg::MODE_INSERT) begin
        seen_keys.push_back(key);
        if (seen_keys.size() > 64) void'(seen_keys.pop_front());
      end
    end
    send_request(mode, key);
  endtask

  initial begin
    logic [wphs_pkg::KEY_W-1:0] k;
    int unsigned                b;

    // Build colliding key sets by brute force; zero sim time.
    while (wrap_keys.size() < 10 || crowd_keys.size() < 48) begin
      k = {$urandom, $urandom};
      if (k != '0) begin
        b = sb.bucket_of(k, 0);
        if (b >= CAP - 4 || b < 4) crowd_keys.push_back(k);
        if (b == CAP - 1) wrap_keys.push_back(k);
      end
    end

    // Reset once; the DUT then runs its clearing pass with busy high, which
    // the first request simply waits out.
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // --- directed ---
    send_request(wphs_pkg::MODE_INSERT, 64'd1);          // inserted
    send_request(wphs_pkg::MODE_INSERT, 64'd1);          // already present
    send_request(wphs_pkg::MODE_SPARE, 64'd1);           // unused mode reads as test
    send_request(wphs_pkg::MODE_DELETE, 64'd1);          // removed
    send_request(wphs_pkg::MODE_DELETE, 64'd1);          // delete of absent key
    send_request(wphs_pkg::MODE_TEST, 64'd1);            // absent
    send_request(wphs_pkg::MODE_INSERT, '0);             // zero key never stored
    send_request(wphs_pkg::MODE_DELETE, '0);
    send_request(wphs_pkg::MODE_INSERT, '1);             // all-ones key
    // Fill a window that wraps from the last slot into slot 0 and beyond.
    for (int i = 0; i < PW; i++) send_request(wphs_pkg::MODE_INSERT, wrap_keys[i]);
    send_request(wphs_pkg::MODE_INSERT, wrap_keys[PW]);  // window full
    send_request(wphs_pkg::MODE_DELETE, wrap_keys[2]);   // open a hole mid-window
    send_request(wphs_pkg::MODE_INSERT, wrap_keys[PW]);  // lands in the hole
    // Hole at the head of the window lets a present key in a second time.
    send_request(wphs_pkg::MODE_DELETE, wrap_keys[0]);
    send_request(wphs_pkg::MODE_INSERT, wrap_keys[5]);   // duplicate copy
    send_request(wphs_pkg::MODE_DELETE, wrap_keys[5]);   // removes the first copy only
    send_request(wphs_pkg::MODE_TEST, wrap_keys[5]);     // second copy still found

    // --- random, with sender gaps except in the tail ---
    for (int n = 0; n < RAND_REQS; n++) begin
      if (n < RAND_REQS - TAIL_REQS && $urandom_range(0, 99) < 30)
        idle_for($urandom_range(1, 16));
      random_request();
    end
    start_i <= 1'b0;

    // Drain: every queued result must show up, then a margin for strays.
    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (PW + 16) @(posedge clk_i);
    if (sb.mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
